// ===== hdl/b64_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and alphabet functions of the base64 codec.
// ---------------------------------------------------------------------------
package b64_pkg;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    SYM_DATA,
    SYM_PAD,
    SYM_BAD
  } sym_kind_t;

  typedef struct packed {
    sym_kind_t  kind;
    logic [5:0] val;
  } sym_t;

  localparam int unsigned JobMax     = 4;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [7:0] CharPad   = 8'h3D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSlash = 8'h2F;

  // One queued job: the results caused by one input transaction.
  typedef struct packed {
    logic [JobMax-1:0][7:0] data;
    logic [1:0]             n_m1;
    logic                   has_data;
    logic                   bad;
    logic                   last;
  } job_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'd71 + {2'b00, v};
    end else if (v < 6'd62) begin
      r = {2'b00, v} - 8'd4;
    end else if (v == 6'd62) begin
      r = CharPlus;
    end else begin
      r = CharSlash;
    end
    return r;
  endfunction

  function automatic sym_t dec_char(input logic [7:0] c);
    sym_t       s;
    logic [7:0] t;
    s.kind = SYM_BAD;
    s.val  = 6'd0;
    t      = 8'd0;
    if (c == CharPad) begin
      s.kind = SYM_PAD;
    end else if (c == CharPlus) begin
      s.kind = SYM_DATA;
      s.val  = 6'd62;
    end else if (c == CharSlash) begin
      s.kind = SYM_DATA;
      s.val  = 6'd63;
    end else if (c >= 8'd65 && c <= 8'd90) begin
      t      = c - 8'd65;
      s.kind = SYM_DATA;
      s.val  = t[5:0];
    end else if (c >= 8'd97 && c <= 8'd122) begin
      t      = c - 8'd71;
      s.kind = SYM_DATA;
      s.val  = t[5:0];
    end else if (c >= 8'd48 && c <= 8'd57) begin
      t      = c + 8'd4;
      s.kind = SYM_DATA;
      s.val  = t[5:0];
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/b64_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// b64_front
// Accepts input transactions, keeps the bit buffer and builds at most one
// job of up to four results per transaction for the queue.
// ---------------------------------------------------------------------------
module b64_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic         cfg_wdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,
  input  wire logic         in_tlast,
  input  wire logic         q_full,
  output logic              q_push,
  output b64_pkg::job_t     q_job
);
  import b64_pkg::*;

  mode_t      mode_r;
  logic [5:0] buf_r, buf_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pad_r, pad_nxt;
  logic [2:0] n;
  logic       accept;
  sym_t       sym;
  job_t       job;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign sym       = dec_char(in_tdata);

  always_comb begin
    job      = '0;
    n        = 3'd0;
    buf_nxt  = buf_r;
    cnt_nxt  = cnt_r;
    pad_nxt  = pad_r;
    if (mode_r == MODE_ENCODE) begin
      job.has_data = 1'b1;
      case (cnt_r)
        3'd2: begin
          job.data[0] = enc_char({buf_r[1:0], in_tdata[7:4]});
          n           = 3'd1;
          buf_nxt     = {2'b00, in_tdata[3:0]};
          cnt_nxt     = 3'd4;
          if (in_tlast) begin
            job.data[1] = enc_char({in_tdata[3:0], 2'b00});
            job.data[2] = CharPad;
            n           = 3'd3;
          end
        end
        3'd4: begin
          job.data[0] = enc_char({buf_r[3:0], in_tdata[7:6]});
          job.data[1] = enc_char(in_tdata[5:0]);
          n           = 3'd2;
          buf_nxt     = 6'd0;
          cnt_nxt     = 3'd0;
        end
        default: begin
          job.data[0] = enc_char(in_tdata[7:2]);
          n           = 3'd1;
          buf_nxt     = {4'b0000, in_tdata[1:0]};
          cnt_nxt     = 3'd2;
          if (in_tlast) begin
            job.data[1] = enc_char({in_tdata[1:0], 4'b0000});
            job.data[2] = CharPad;
            job.data[3] = CharPad;
            n           = 3'd4;
          end
        end
      endcase
    end else if (!pad_r) begin
      unique case (sym.kind)
        SYM_PAD: begin
          pad_nxt = 1'b1;
        end
        SYM_BAD: begin
          job.bad = 1'b1;
          n       = 3'd1;
        end
        default: begin
          case (cnt_r)
            3'd6: begin
              job.data[0]  = {buf_r, sym.val[5:4]};
              job.has_data = 1'b1;
              n            = 3'd1;
              buf_nxt      = {2'b00, sym.val[3:0]};
              cnt_nxt      = 3'd4;
            end
            3'd4: begin
              job.data[0]  = {buf_r[3:0], sym.val[5:2]};
              job.has_data = 1'b1;
              n            = 3'd1;
              buf_nxt      = {4'b0000, sym.val[1:0]};
              cnt_nxt      = 3'd2;
            end
            3'd2: begin
              job.data[0]  = {buf_r[1:0], sym.val};
              job.has_data = 1'b1;
              n            = 3'd1;
              buf_nxt      = 6'd0;
              cnt_nxt      = 3'd0;
            end
            default: begin
              buf_nxt = sym.val;
              cnt_nxt = 3'd6;
            end
          endcase
        end
      endcase
    end
    if (in_tlast) begin
      if (n == 3'd0) begin
        n = 3'd1;
      end
      buf_nxt = 6'd0;
      cnt_nxt = 3'd0;
      pad_nxt = 1'b0;
    end
    job.last = in_tlast;
    job.n_m1 = 2'(n - 3'd1);
  end

  assign q_push = accept && (n != 3'd0);
  assign q_job  = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENCODE;
      buf_r  <= '0;
      cnt_r  <= '0;
      pad_r  <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= mode_t'(cfg_wdata);
      buf_r  <= '0;
      cnt_r  <= '0;
      pad_r  <= 1'b0;
    end else if (accept) begin
      buf_r <= buf_nxt;
      cnt_r <= cnt_nxt;
      pad_r <= pad_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_even: assert property (@(posedge clk) disable iff (!rst_n) !cnt_r[0])
    else $error("bit count is odd");
  a_enc_state: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_ENCODE) |-> (!pad_r && cnt_r != 3'd6))
    else $error("decode-only state seen while encoding");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tlast && !cfg_we) |=> (cnt_r == 3'd0 && !pad_r))
    else $error("message state not cleared after last transaction");
`endif

endmodule
`default_nettype wire

// ===== hdl/b64_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// b64_queue
// Short job queue between the front and back parts of the codec.
// ---------------------------------------------------------------------------
module b64_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  b64_pkg::job_t      din,
  output logic               full,
  input  wire logic          pop,
  output b64_pkg::job_t      dout,
  output logic               empty
);
  import b64_pkg::*;

  job_t             ent_r [QueueDepth];
  logic [QPtrW-1:0] wr_r, rd_r;
  logic [QCntW-1:0] cnt_r;

  assign full  = (cnt_r == QCntW'(QueueDepth));
  assign empty = (cnt_r == '0);
  assign dout  = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == QPtrW'(QueueDepth - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == QPtrW'(QueueDepth - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full) && !(pop && empty))
    else $error("queue overflow or underflow");
`endif

endmodule
`default_nettype wire

// ===== hdl/b64_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// b64_back
// Takes jobs from the queue and sends their results one per transaction
// through an output register.
// ---------------------------------------------------------------------------
module b64_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  b64_pkg::job_t    q_job,
  input  wire logic        q_empty,
  output logic             q_pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);
  import b64_pkg::*;

  logic       valid_r;
  logic [7:0] data_r;
  logic       hd_r, bad_r, last_r;
  logic [1:0] idx_r;
  logic       load, at_end;

  assign load   = !q_empty && (!valid_r || out_tready);
  assign at_end = (idx_r == q_job.n_m1);
  assign q_pop  = load && at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= at_end ? 2'd0 : idx_r + 2'd1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= q_job.data[idx_r];
      hd_r   <= q_job.has_data;
      bad_r  <= q_job.bad;
      last_r <= q_job.last && at_end;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = {bad_r, hd_r};
  assign out_tlast  = last_r;

`ifndef SYNTHESIS
  a_mid_job: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != 2'd0) |-> !q_empty)
    else $error("job left the queue before all results were sent");
  a_bad_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && bad_r) |-> (!hd_r && data_r == 8'd0))
    else $error("bad-character result carries data");
`endif

endmodule
`default_nettype wire

// ===== hdl/base64_codec.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// base64_codec
// Base64 encoder and decoder with the standard alphabet and '=' padding.
// ---------------------------------------------------------------------------
// The mode register selects encoding (0) or decoding (1); writing it clears
// the message state. The block accepts one input transaction per cycle while
// its two-job queue has room, and the output side sends one result per cycle
// while a job is queued and the receiver is ready. Encoding gives one or two
// characters per byte and up to four on the last byte of a message, so the
// output port paces the input. Decoding gives at most one result per
// character and runs at one character per cycle while the output is ready.
module base64_codec (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,   // mode
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,    // data_in
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,   // data_out
  output logic [1:0]      out_tuser,   // bit 0 has_data, bit 1 bad_char
  output logic            out_tlast
);
  import b64_pkg::*;

  job_t push_job, head_job;
  logic q_push, q_pop, q_full, q_empty;

  b64_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  b64_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (push_job),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (head_job),
    .empty (q_empty)
  );

  b64_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_job      (head_job),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
